FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define GCRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds through reset
`define GCRC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/gcrc_pkg.sv
package gcrc_pkg;

   // override modes
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_AUTO  = 2'd0;
   localparam mode_type MODE_ON    = 2'd1;
   localparam mode_type MODE_OFF   = 2'd2;
   localparam mode_type MODE_UNDEF = 2'd3;

   // request kinds
   typedef logic [1:0] req_kind_type;
   localparam req_kind_type REQ_TICK    = 2'd0;
   localparam req_kind_type REQ_FAN     = 2'd1;
   localparam req_kind_type REQ_EXHAUST = 2'd2;

   // register indexes
   typedef logic [2:0] csr_idx_type;
   localparam csr_idx_type CSR_LIGHT_ON  = 3'd0;
   localparam csr_idx_type CSR_LIGHT_OFF = 3'd1;
   localparam csr_idx_type CSR_TEMP_MAX  = 3'd2;
   localparam csr_idx_type CSR_HUM_MAX   = 3'd3;
   localparam csr_idx_type CSR_COLD      = 3'd4;
   localparam csr_idx_type CSR_OVERRIDE  = 3'd5;

   // register reset values
   localparam logic [10:0]        RST_LIGHT_ON  = 11'd360;
   localparam logic [10:0]        RST_LIGHT_OFF = 11'd0;
   localparam logic signed [11:0] RST_TEMP_MAX  = 12'sd280;
   localparam logic [9:0]         RST_HUM_MAX   = 10'd700;
   localparam logic signed [11:0] RST_COLD      = 12'sd180;
   localparam logic [31:0]        RST_OVERRIDE  = 32'd1800000;

   // climate constants, tenths and minutes
   localparam logic signed [11:0] HUM_HYST       = 12'sd50;
   localparam logic signed [12:0] TEMP_HYST      = 13'sd20;
   localparam logic [5:0]         PULSE_MINUTES  = 6'd5;
   localparam logic [5:0]         WINTER_MINUTES = 6'd2;
   localparam logic [10:0]        MIN_PER_HOUR   = 11'd60;

   typedef struct packed {
      logic [10:0]        light_on_minute;
      logic [10:0]        light_off_minute;
      logic signed [11:0] temp_max;
      logic [9:0]         hum_max;
      logic signed [11:0] cold_limit;
      logic [31:0]        override_ms;
   } cfg_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [31:0]        now_ms;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic signed [11:0] temp_sample;
      logic               temp_valid;
      logic [9:0]         hum_sample;
      logic               hum_valid;
      logic [1:0]         mode;
   } req_item_type;

   typedef struct packed {
      logic               light_on;
      logic               exhaust_on;
      logic               fan_on;
      mode_type           fan_mode;
      mode_type           exhaust_mode;
      logic [31:0]        fan_remaining_ms;
      logic [31:0]        exhaust_remaining_ms;
      logic signed [11:0] temp_held;
      logic [9:0]         hum_held;
   } rsp_item_type;

   // undefined mode code counts as auto
   function automatic mode_type norm_mode(input logic [1:0] m);
      return (m == MODE_UNDEF) ? MODE_AUTO : m;
   endfunction

   // hour is a multiple of three
   function automatic logic pulse_hour(input logic [4:0] h);
      logic r;
      case (h) inside
         5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27, 5'd30: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/grow_climate_relay_controller.sv
// channel   | direction | handshake               | payload
// req_      | in        | req_valid / req_ready   | request kind, time, samples, mode
// rsp_      | out       | rsp_valid / rsp_ready   | relays, modes, override time left, held samples
// csr_      | in        | csr_valid / csr_ready   | register index and write data
//
// one transaction a cycle unless rsp_ready stalls it; a response waits in the response register
// input register, then mode, expiry and relay logic straight into the response register
// synchronous active-high reset: modes auto, fan relay on, registers to defaults
// req_ready is high while the input or response register is empty, or the response is taken
// csr writes are always ready and meant for idle periods only
module grow_climate_relay_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [31:0]            req_now_ms,
   input  logic [4:0]             req_hour,
   input  logic [5:0]             req_minute,
   input  logic signed [11:0]     req_temp_sample,
   input  logic                   req_temp_valid,
   input  logic [9:0]             req_hum_sample,
   input  logic                   req_hum_valid,
   input  logic [1:0]             req_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_light_on,
   output logic                   rsp_exhaust_on,
   output logic                   rsp_fan_on,
   output logic [1:0]             rsp_fan_mode_out,
   output logic [1:0]             rsp_exhaust_mode_out,
   output logic [31:0]            rsp_fan_remaining_ms,
   output logic [31:0]            rsp_exhaust_remaining_ms,
   output logic signed [11:0]     rsp_temp_held,
   output logic [9:0]             rsp_hum_held,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  gcrc_pkg::csr_idx_type  csr_index,
   input  logic [31:0]            csr_wdata
);
   import gcrc_pkg::*;

   cfg_type      cfg;
   req_item_type s1_item_ff, s1_item_in;
   logic         s1_vld_ff, s1_vld_in;
   rsp_item_type rsp_item_ff, rsp_calc;
   logic         rsp_vld_ff, rsp_vld_in;
   logic         advance, fire, req_take;

   gcrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // pipeline flow control
   assign advance   = !rsp_vld_ff || rsp_ready;
   assign fire      = s1_vld_ff && advance;
   assign req_ready = !s1_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_item_in.kind        = req_type;
      s1_item_in.now_ms      = req_now_ms;
      s1_item_in.hour        = req_hour;
      s1_item_in.minute      = req_minute;
      s1_item_in.temp_sample = req_temp_sample;
      s1_item_in.temp_valid  = req_temp_valid;
      s1_item_in.hum_sample  = req_hum_sample;
      s1_item_in.hum_valid   = req_hum_valid;
      s1_item_in.mode        = req_mode;
   end

   assign s1_vld_in  = req_take ? 1'b1 : (fire ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = advance ? s1_vld_ff : rsp_vld_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= s1_item_in;
      end
   end

   gcrc_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (s1_item_ff),
      .cfg   (cfg),
      .rsp   (rsp_calc)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= rsp_calc;
      end
   end

   assign rsp_valid                = rsp_vld_ff;
   assign rsp_light_on             = rsp_item_ff.light_on;
   assign rsp_exhaust_on           = rsp_item_ff.exhaust_on;
   assign rsp_fan_on               = rsp_item_ff.fan_on;
   assign rsp_fan_mode_out         = rsp_item_ff.fan_mode;
   assign rsp_exhaust_mode_out     = rsp_item_ff.exhaust_mode;
   assign rsp_fan_remaining_ms     = rsp_item_ff.fan_remaining_ms;
   assign rsp_exhaust_remaining_ms = rsp_item_ff.exhaust_remaining_ms;
   assign rsp_temp_held            = rsp_item_ff.temp_held;
   assign rsp_hum_held             = rsp_item_ff.hum_held;

endmodule

FILE: design/gcrc_csr.sv
module gcrc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  gcrc_pkg::csr_idx_type csr_index,
   input  logic [31:0]          csr_wdata,
   output gcrc_pkg::cfg_type    cfg
);
   import gcrc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // writes are taken in any cycle
   assign csr_ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LIGHT_ON:  cfg_in.light_on_minute  = csr_wdata[10:0];
            CSR_LIGHT_OFF: cfg_in.light_off_minute = csr_wdata[10:0];
            CSR_TEMP_MAX:  cfg_in.temp_max         = $signed(csr_wdata[11:0]);
            CSR_HUM_MAX:   cfg_in.hum_max          = csr_wdata[9:0];
            CSR_COLD:      cfg_in.cold_limit       = $signed(csr_wdata[11:0]);
            CSR_OVERRIDE:  cfg_in.override_ms      = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_on_minute  <= RST_LIGHT_ON;
         cfg_ff.light_off_minute <= RST_LIGHT_OFF;
         cfg_ff.temp_max         <= RST_TEMP_MAX;
         cfg_ff.hum_max          <= RST_HUM_MAX;
         cfg_ff.cold_limit       <= RST_COLD;
         cfg_ff.override_ms      <= RST_OVERRIDE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/gcrc_core.sv
module gcrc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  gcrc_pkg::req_item_type item,
   input  gcrc_pkg::cfg_type      cfg,
   output gcrc_pkg::rsp_item_type rsp
);
   import gcrc_pkg::*;

   logic signed [11:0] temp_ff, temp_in;
   logic [9:0]         hum_ff, hum_in;
   mode_type           fan_mode_ff, fan_mode_in;
   mode_type           exh_mode_ff, exh_mode_in;
   logic [31:0]        fan_start_ff, fan_start_in;
   logic [31:0]        exh_start_ff, exh_start_in;
   logic               exh_relay_ff, exh_relay_in;
   logic               fan_relay_ff, fan_relay_in;
   logic               light_ff, light_in;

   logic               is_tick, is_fan, is_exh;
   mode_type           cmd_mode;
   logic [10:0]        mnow;
   logic [31:0]        fan_el, exh_el, fan_left, exh_left;
   logic               fan_over, exh_over;
   logic [31:0]        fan_rem, exh_rem;
   logic               hot, humid, pulse, hum_prio, cold, cool_dry;
   logic signed [11:0] hum_lo, hum_s;
   logic signed [12:0] temp_lo, temp_s;
   logic               auto_relay;

   assign is_tick  = (item.kind == REQ_TICK);
   assign is_fan   = (item.kind == REQ_FAN);
   assign is_exh   = (item.kind == REQ_EXHAUST);
   assign cmd_mode = norm_mode(item.mode);

   // sample capture
   assign temp_in = (is_tick && item.temp_valid) ? item.temp_sample : temp_ff;
   assign hum_in  = (is_tick && item.hum_valid) ? item.hum_sample : hum_ff;

   // light window, may wrap past midnight
   assign mnow = ({6'd0, item.hour} * MIN_PER_HOUR) + {5'd0, item.minute};
   always_comb begin
      light_in = light_ff;
      if (is_tick) begin
         if (cfg.light_on_minute < cfg.light_off_minute) begin
            light_in = (mnow >= cfg.light_on_minute) && (mnow < cfg.light_off_minute);
         end else begin
            light_in = (mnow >= cfg.light_on_minute) || (mnow < cfg.light_off_minute);
         end
      end
   end

   // wrap-safe elapsed time since each override started
   assign fan_el   = item.now_ms - fan_start_ff;
   assign exh_el   = item.now_ms - exh_start_ff;
   assign fan_over = fan_el > cfg.override_ms;
   assign exh_over = exh_el > cfg.override_ms;
   assign fan_left = cfg.override_ms - fan_el;
   assign exh_left = cfg.override_ms - exh_el;

   // mode updates: commands set, ticks expire
   always_comb begin
      fan_mode_in  = fan_mode_ff;
      exh_mode_in  = exh_mode_ff;
      fan_start_in = fan_start_ff;
      exh_start_in = exh_start_ff;
      if (is_tick) begin
         if (fan_mode_ff != MODE_AUTO && fan_over) fan_mode_in = MODE_AUTO;
         if (exh_mode_ff != MODE_AUTO && exh_over) exh_mode_in = MODE_AUTO;
      end else if (is_fan) begin
         fan_mode_in = cmd_mode;
         if (cmd_mode != MODE_AUTO) fan_start_in = item.now_ms;
      end else if (is_exh) begin
         exh_mode_in = cmd_mode;
         if (cmd_mode != MODE_AUTO) exh_start_in = item.now_ms;
      end
   end

   // time left on each override, a fresh command has the full duration
   always_comb begin
      if (fan_mode_in == MODE_AUTO) fan_rem = '0;
      else if (is_fan)              fan_rem = cfg.override_ms;
      else if (fan_over)            fan_rem = '0;
      else                          fan_rem = fan_left;
      if (exh_mode_in == MODE_AUTO) exh_rem = '0;
      else if (is_exh)              exh_rem = cfg.override_ms;
      else if (exh_over)            exh_rem = '0;
      else                          exh_rem = exh_left;
   end

   // exhaust auto decision on the freshly stored samples
   assign hum_s    = $signed({2'b00, hum_in});
   assign hum_lo   = $signed({2'b00, cfg.hum_max}) - HUM_HYST;
   assign temp_s   = $signed({temp_in[11], temp_in});
   assign temp_lo  = $signed({cfg.temp_max[11], cfg.temp_max}) - TEMP_HYST;
   assign hot      = temp_in > cfg.temp_max;
   assign humid    = hum_in > cfg.hum_max;
   assign pulse    = pulse_hour(item.hour) && (item.minute < PULSE_MINUTES);
   assign hum_prio = humid || (exh_relay_ff && (hum_s > hum_lo));
   assign cold     = temp_in < cfg.cold_limit;
   assign cool_dry = (temp_s < temp_lo) && (hum_s < hum_lo);

   always_comb begin
      if (cold && !hum_prio)          auto_relay = item.minute < WINTER_MINUTES;
      else if (hot || humid || pulse) auto_relay = 1'b1;
      else if (cool_dry)              auto_relay = 1'b0;
      else                            auto_relay = exh_relay_ff;
   end

   // relays move only on ticks
   always_comb begin
      exh_relay_in = exh_relay_ff;
      fan_relay_in = fan_relay_ff;
      if (is_tick) begin
         fan_relay_in = (fan_mode_in != MODE_OFF);
         case (exh_mode_in)
            MODE_ON:  exh_relay_in = 1'b1;
            MODE_OFF: exh_relay_in = 1'b0;
            default:  exh_relay_in = auto_relay;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff      <= '0;
         hum_ff       <= '0;
         fan_mode_ff  <= MODE_AUTO;
         exh_mode_ff  <= MODE_AUTO;
         fan_start_ff <= '0;
         exh_start_ff <= '0;
         exh_relay_ff <= 1'b0;
         fan_relay_ff <= 1'b1;
         light_ff     <= 1'b0;
      end else if (fire) begin
         temp_ff      <= temp_in;
         hum_ff       <= hum_in;
         fan_mode_ff  <= fan_mode_in;
         exh_mode_ff  <= exh_mode_in;
         fan_start_ff <= fan_start_in;
         exh_start_ff <= exh_start_in;
         exh_relay_ff <= exh_relay_in;
         fan_relay_ff <= fan_relay_in;
         light_ff     <= light_in;
      end
   end

   // result of this transaction
   always_comb begin
      rsp.light_on             = light_in;
      rsp.exhaust_on           = exh_relay_in;
      rsp.fan_on               = fan_relay_in;
      rsp.fan_mode             = fan_mode_in;
      rsp.exhaust_mode         = exh_mode_in;
      rsp.fan_remaining_ms     = fan_rem;
      rsp.exhaust_remaining_ms = exh_rem;
      rsp.temp_held            = temp_in;
      rsp.hum_held             = hum_in;
   end

endmodule

FILE: design/gcrc_checker.sv
`include "assert_macros.svh"

module gcrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_light_on,
   input logic [1:0]  rsp_fan_mode_out,
   input logic [1:0]  rsp_exhaust_mode_out,
   input logic [31:0] rsp_fan_remaining_ms,
   input logic [31:0] rsp_exhaust_remaining_ms
);
   import gcrc_pkg::*;

   // nothing is offered right after reset
   `GCRC_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response stays offered
   `GCRC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")

   // a stalled response keeps its override times left and its light state
   `GCRC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_fan_remaining_ms) && $stable(rsp_exhaust_remaining_ms) && $stable(rsp_light_on), "response changed under stall")

   // auto mode carries no override time
   `GCRC_ASSERT(a_fan_auto_zero, clock, reset, rsp_valid && rsp_fan_mode_out == MODE_AUTO |-> rsp_fan_remaining_ms == 32'd0, "fan time left in auto")

   `GCRC_ASSERT(a_exh_auto_zero, clock, reset, rsp_valid && rsp_exhaust_mode_out == MODE_AUTO |-> rsp_exhaust_remaining_ms == 32'd0, "exhaust time left in auto")

endmodule

bind grow_climate_relay_controller gcrc_checker u_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import gcrc_pkg::*;

   // codes the package leaves out
   localparam req_kind_type REQ_UNDEF  = 2'd3;
   localparam csr_idx_type  CSR_SPARE  = 3'd6;
   localparam int           PULSE_EVERY_H = 3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = '0;
   logic [31:0]        req_now_ms = '0;
   logic [4:0]         req_hour = '0;
   logic [5:0]         req_minute = '0;
   logic signed [11:0] req_temp_sample = '0;
   logic               req_temp_valid = 1'b0;
   logic [9:0]         req_hum_sample = '0;
   logic               req_hum_valid = 1'b0;
   logic [1:0]         req_mode = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_light_on;
   logic               rsp_exhaust_on;
   logic               rsp_fan_on;
   logic [1:0]         rsp_fan_mode_out;
   logic [1:0]         rsp_exhaust_mode_out;
   logic [31:0]        rsp_fan_remaining_ms;
   logic [31:0]        rsp_exhaust_remaining_ms;
   logic signed [11:0] rsp_temp_held;
   logic [9:0]         rsp_hum_held;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_idx_type        csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // predicted controller state and register copy
   cfg_type            climate_cfg;
   logic signed [11:0] held_temp;
   logic [9:0]         held_hum;
   mode_type           fan_mode_q;
   mode_type           exh_mode_q;
   logic [31:0]        fan_start;
   logic [31:0]        exh_start;
   logic               exh_relay;
   logic               fan_relay;
   logic               light_relay;

   rsp_item_type       pending_reports[$];
   rsp_item_type       oldest_report;
   int                 errors = 0;
   bit                 idle_on = 1'b0;
   int                 stall_left = 0;
   logic [31:0]        wall_ms = '0;

   grow_climate_relay_controller u_top (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_type                 (req_type),
      .req_now_ms               (req_now_ms),
      .req_hour                 (req_hour),
      .req_minute               (req_minute),
      .req_temp_sample          (req_temp_sample),
      .req_temp_valid           (req_temp_valid),
      .req_hum_sample           (req_hum_sample),
      .req_hum_valid            (req_hum_valid),
      .req_mode                 (req_mode),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_light_on             (rsp_light_on),
      .rsp_exhaust_on           (rsp_exhaust_on),
      .rsp_fan_on               (rsp_fan_on),
      .rsp_fan_mode_out         (rsp_fan_mode_out),
      .rsp_exhaust_mode_out     (rsp_exhaust_mode_out),
      .rsp_fan_remaining_ms     (rsp_fan_remaining_ms),
      .rsp_exhaust_remaining_ms (rsp_exhaust_remaining_ms),
      .rsp_temp_held            (rsp_temp_held),
      .rsp_hum_held             (rsp_hum_held),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic override_lapsed(mode_type md, logic [31:0] start, logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - start;
      return (md != MODE_AUTO) && (elapsed > climate_cfg.override_ms);
   endfunction

   function automatic logic [31:0] override_left(mode_type md, logic [31:0] start,
                                                 logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - start;
      if (md == MODE_AUTO) return '0;
      return (elapsed > climate_cfg.override_ms) ? 32'd0 : climate_cfg.override_ms - elapsed;
   endfunction

   // apply one transaction to the predicted state and return the report it gives
   function automatic rsp_item_type advance_climate(input req_item_type it);
      rsp_item_type r;
      mode_type     m;
      int           mnow, t, h, tmax, hm;
      logic         hot, humid, pulse, hum_prio;
      m = (it.mode == MODE_UNDEF) ? MODE_AUTO : mode_type'(it.mode);
      case (it.kind)
         REQ_TICK: begin
            if (it.temp_valid) held_temp = it.temp_sample;
            if (it.hum_valid) held_hum = it.hum_sample;
            // light window, wrapping past midnight when on is not below off
            mnow = int'(it.hour) * int'(MIN_PER_HOUR) + int'(it.minute);
            if (climate_cfg.light_on_minute < climate_cfg.light_off_minute)
               light_relay = mnow >= int'(climate_cfg.light_on_minute) &&
                             mnow < int'(climate_cfg.light_off_minute);
            else
               light_relay = mnow >= int'(climate_cfg.light_on_minute) ||
                             mnow < int'(climate_cfg.light_off_minute);
            // lapsed overrides fall back to auto
            if (override_lapsed(exh_mode_q, exh_start, it.now_ms)) exh_mode_q = MODE_AUTO;
            if (override_lapsed(fan_mode_q, fan_start, it.now_ms)) fan_mode_q = MODE_AUTO;
            fan_relay = (fan_mode_q != MODE_OFF);
            // exhaust: forced, or limits with hysteresis, breathing and winter pulses
            if (exh_mode_q == MODE_ON) begin
               exh_relay = 1'b1;
            end else if (exh_mode_q == MODE_OFF) begin
               exh_relay = 1'b0;
            end else begin
               t = int'(held_temp);
               h = int'(held_hum);
               tmax = int'($signed(climate_cfg.temp_max));
               hm = int'(climate_cfg.hum_max);
               hot = t > tmax;
               humid = h > hm;
               pulse = ((int'(it.hour) % PULSE_EVERY_H) == 0) && (it.minute < PULSE_MINUTES);
               hum_prio = humid || (exh_relay && h > hm - int'(HUM_HYST));
               if (t < int'($signed(climate_cfg.cold_limit)) && !hum_prio)
                  exh_relay = it.minute < WINTER_MINUTES;
               else if (hot || humid || pulse)
                  exh_relay = 1'b1;
               else if (t < tmax - int'(TEMP_HYST) && h < hm - int'(HUM_HYST))
                  exh_relay = 1'b0;
            end
         end
         REQ_FAN: begin
            fan_mode_q = m;
            if (m != MODE_AUTO) fan_start = it.now_ms;
         end
         REQ_EXHAUST: begin
            exh_mode_q = m;
            if (m != MODE_AUTO) exh_start = it.now_ms;
         end
         default: ;
      endcase
      r.light_on             = light_relay;
      r.exhaust_on           = exh_relay;
      r.fan_on               = fan_relay;
      r.fan_mode             = fan_mode_q;
      r.exhaust_mode         = exh_mode_q;
      r.fan_remaining_ms     = override_left(fan_mode_q, fan_start, it.now_ms);
      r.exhaust_remaining_ms = override_left(exh_mode_q, exh_start, it.now_ms);
      r.temp_held            = held_temp;
      r.hum_held             = held_hum;
      return r;
   endfunction

   function automatic req_item_type make_tick(logic [31:0] now, int hour, int minute, int temp,
                                              logic tv, int hum, logic hv);
      req_item_type it;
      it.kind        = REQ_TICK;
      it.now_ms      = now;
      it.hour        = 5'(hour);
      it.minute      = 6'(minute);
      it.temp_sample = 12'(temp);
      it.temp_valid  = tv;
      it.hum_sample  = 10'(hum);
      it.hum_valid   = hv;
      it.mode        = 2'($urandom);
      return it;
   endfunction

   // command with the tick fields left as noise
   function automatic req_item_type make_cmd(req_kind_type kind, logic [31:0] now, mode_type md);
      req_item_type it;
      it = make_tick(now, $urandom, $urandom, $urandom, 1'($urandom), $urandom, 1'($urandom));
      it.kind = kind;
      it.mode = md;
      return it;
   endfunction

   // random transaction steered towards thresholds, window edges and expiry
   function automatic req_item_type rand_climate_item();
      req_item_type it;
      int           s, m;
      s = $urandom_range(0, 99);
      it.kind = (s < 70) ? REQ_TICK : (s < 82) ? REQ_FAN : (s < 94) ? REQ_EXHAUST : REQ_UNDEF;
      // time stamp, mostly moving forward
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: wall_ms = wall_ms + $urandom_range(0, 3000);
         6: wall_ms = wall_ms + $urandom_range(0, climate_cfg.override_ms);
         7: wall_ms = fan_start + climate_cfg.override_ms + $urandom_range(0, 1);
         8: wall_ms = exh_start + climate_cfg.override_ms + $urandom_range(0, 1);
         default: wall_ms = $urandom;
      endcase
      it.now_ms = wall_ms;
      // time of day
      case ($urandom_range(0, 9))
         6, 7: begin
            m = ($urandom_range(0, 1) ? int'(climate_cfg.light_on_minute)
                                      : int'(climate_cfg.light_off_minute))
                + $urandom_range(0, 2) - 1;
            if (m < 0) m = 0;
            it.hour   = 5'(m / 60);
            it.minute = 6'(m % 60);
         end
         8: begin
            it.hour   = 5'($urandom);
            it.minute = 6'($urandom);
         end
         9: begin
            it.hour   = 5'(PULSE_EVERY_H * $urandom_range(0, 7));
            it.minute = 6'($urandom_range(0, 6));
         end
         default: begin
            it.hour   = 5'($urandom_range(0, 23));
            it.minute = 6'($urandom_range(0, 59));
         end
      endcase
      // samples near the limits, across the legal span, or any code at all
      case ($urandom_range(0, 9))
         0, 1, 2, 3:
            it.temp_sample = 12'(int'($signed(climate_cfg.temp_max)) + $urandom_range(0, 60) - 30);
         4, 5:
            it.temp_sample = 12'(int'($signed(climate_cfg.cold_limit)) + $urandom_range(0, 60) - 30);
         6, 7: it.temp_sample = 12'(int'($urandom_range(0, 1650)) - 400);
         default: it.temp_sample = 12'($urandom);
      endcase
      if ($urandom_range(0, 9) < 6)
         it.hum_sample = 10'(int'(climate_cfg.hum_max) + $urandom_range(0, 120) - 60);
      else
         it.hum_sample = 10'($urandom);
      it.temp_valid = ($urandom_range(0, 9) != 0);
      it.hum_valid  = ($urandom_range(0, 9) != 0);
      it.mode       = 2'($urandom);
      return it;
   endfunction

   // send one request transaction and record the report it should give
   task automatic send_req(input req_item_type it);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_type        <= it.kind;
      req_now_ms      <= it.now_ms;
      req_hour        <= it.hour;
      req_minute      <= it.minute;
      req_temp_sample <= it.temp_sample;
      req_temp_valid  <= it.temp_valid;
      req_hum_sample  <= it.hum_sample;
      req_hum_valid   <= it.hum_valid;
      req_mode        <= it.mode;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_reports.push_back(advance_climate(it));
   endtask

   // hold off until every outstanding report has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_LIGHT_ON:  climate_cfg.light_on_minute  = data[10:0];
         CSR_LIGHT_OFF: climate_cfg.light_off_minute = data[10:0];
         CSR_TEMP_MAX:  climate_cfg.temp_max         = data[11:0];
         CSR_HUM_MAX:   climate_cfg.hum_max          = data[9:0];
         CSR_COLD:      climate_cfg.cold_limit       = data[11:0];
         CSR_OVERRIDE:  climate_cfg.override_ms      = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input int on_min, input int off_min, input int tmax,
                                 input int hmax, input int cold, input logic [31:0] dur);
      drain();
      write_csr(CSR_LIGHT_ON, 32'(on_min));
      write_csr(CSR_LIGHT_OFF, 32'(off_min));
      write_csr(CSR_TEMP_MAX, 32'(tmax));
      write_csr(CSR_HUM_MAX, 32'(hmax));
      write_csr(CSR_COLD, 32'(cold));
      write_csr(CSR_OVERRIDE, dur);
   endtask

   // held values at reset, undefined request, field extremes
   task automatic test_reset_and_undefined();
      idle_on = 1'b0;
      send_req(make_tick(32'd0, 0, 0, 500, 1'b0, 900, 1'b0));
      send_req(make_cmd(REQ_UNDEF, 32'hFFFF_FFFF, MODE_ON));
      send_req(make_tick(32'hFFFF_FFFF, 31, 63, -2048, 1'b1, 1023, 1'b1));
      send_req(make_tick(32'h8000_0000, 23, 59, 2047, 1'b1, 0, 1'b1));
   endtask

   // hot, hysteresis hold, humid, humidity priority, winter and breathing pulses, light edges
   task automatic test_exhaust_thresholds();
      idle_on = 1'b0;
      send_req(make_tick(32'd100, 7, 10, 281, 1'b1, 0, 1'b1));
      send_req(make_tick(32'd200, 7, 11, 270, 1'b1, 690, 1'b1));
      send_req(make_tick(32'd300, 7, 12, 250, 1'b1, 640, 1'b1));
      send_req(make_tick(32'd400, 7, 13, 250, 1'b1, 701, 1'b1));
      send_req(make_tick(32'd500, 7, 14, 100, 1'b1, 660, 1'b1));
      send_req(make_tick(32'd600, 7, 1, 100, 1'b1, 600, 1'b1));
      send_req(make_tick(32'd700, 7, 2, 100, 1'b1, 600, 1'b1));
      send_req(make_tick(32'd800, 3, 4, 200, 1'b1, 600, 1'b1));
      send_req(make_tick(32'd900, 3, 5, 200, 1'b1, 600, 1'b1));
      send_req(make_tick(32'd1000, 5, 59, 200, 1'b0, 600, 1'b0));
      send_req(make_tick(32'd1100, 6, 0, 200, 1'b0, 600, 1'b0));
   endtask

   // forced modes across the timestamp wrap, expiry on the exact boundary, back to auto
   task automatic test_overrides();
      logic [31:0] base;
      base = 32'hFFFF_FF00;
      idle_on = 1'b0;
      send_req(make_cmd(REQ_FAN, base, MODE_OFF));
      send_req(make_cmd(REQ_EXHAUST, base, MODE_ON));
      send_req(make_tick(32'h0000_1000, 12, 30, 200, 1'b1, 600, 1'b1));
      send_req(make_tick(base + RST_OVERRIDE, 12, 31, 200, 1'b1, 600, 1'b1));
      send_req(make_tick(base + RST_OVERRIDE + 32'd1, 12, 32, 200, 1'b1, 600, 1'b1));
      send_req(make_cmd(REQ_FAN, 32'h10, MODE_UNDEF));
      send_req(make_cmd(REQ_EXHAUST, 32'h20, MODE_OFF));
      send_req(make_cmd(REQ_FAN, 32'h30, MODE_ON));
      send_req(make_tick(32'h40, 12, 33, 300, 1'b1, 800, 1'b1));
      send_req(make_cmd(REQ_EXHAUST, 32'h50, MODE_AUTO));
      send_req(make_cmd(REQ_FAN, 32'h60, MODE_AUTO));
      send_req(make_tick(32'h70, 12, 34, 300, 1'b1, 800, 1'b1));
   endtask

   // register settings from one extreme to the other, random traffic under each
   task automatic test_register_sweep();
      for (int k = 0; k < 6; k++) begin
         case (k)
            0: apply_settings(0, 1439, 2047, 1023, -2048, 32'd0);
            1: apply_settings(1439, 0, -2048, 0, 2047, 32'hFFFF_FFFF);
            2: apply_settings(1200, 1200, 250, 600, 150, 32'd1000);
            3: apply_settings(1320, 300, 300, 650, 120, 32'd60000);
            4: begin
               apply_settings($urandom_range(0, 1439), $urandom_range(0, 1439),
                              int'($urandom_range(0, 1650)) - 400, $urandom_range(0, 1000),
                              int'($urandom_range(0, 1650)) - 400, $urandom_range(0, 200000));
               // unused index must leave every register alone
               write_csr(CSR_SPARE, $urandom);
            end
            default: apply_settings(RST_LIGHT_ON, RST_LIGHT_OFF, RST_TEMP_MAX, RST_HUM_MAX,
                                    RST_COLD, RST_OVERRIDE);
         endcase
         idle_on = 1'b1;
         repeat (40) send_req(rand_climate_item());
      end
   endtask

   // long random run with one full drain and one stretch without idling
   task automatic test_random_climate(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) drain();
         idle_on = !(i >= count / 2 && i < count / 2 + 40);
         send_req(rand_climate_item());
      end
   endtask

   // response side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("response transaction with no report expected");
            errors++;
         end else begin
            oldest_report = pending_reports.pop_front();
            check_field("light_on", oldest_report.light_on, rsp_light_on);
            check_field("exhaust_on", oldest_report.exhaust_on, rsp_exhaust_on);
            check_field("fan_on", oldest_report.fan_on, rsp_fan_on);
            check_field("fan_mode_out", oldest_report.fan_mode, rsp_fan_mode_out);
            check_field("exhaust_mode_out", oldest_report.exhaust_mode, rsp_exhaust_mode_out);
            check_field("fan_remaining_ms", oldest_report.fan_remaining_ms,
                        rsp_fan_remaining_ms);
            check_field("exhaust_remaining_ms", oldest_report.exhaust_remaining_ms,
                        rsp_exhaust_remaining_ms);
            check_field("temp_held", $signed(oldest_report.temp_held), $signed(rsp_temp_held));
            check_field("hum_held", oldest_report.hum_held, rsp_hum_held);
         end
      end
   end

   // run limit
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      // predicted state at reset
      climate_cfg.light_on_minute  = RST_LIGHT_ON;
      climate_cfg.light_off_minute = RST_LIGHT_OFF;
      climate_cfg.temp_max         = RST_TEMP_MAX;
      climate_cfg.hum_max          = RST_HUM_MAX;
      climate_cfg.cold_limit       = RST_COLD;
      climate_cfg.override_ms      = RST_OVERRIDE;
      held_temp   = '0;
      held_hum    = '0;
      fan_mode_q  = MODE_AUTO;
      exh_mode_q  = MODE_AUTO;
      fan_start   = '0;
      exh_start   = '0;
      exh_relay   = 1'b0;
      fan_relay   = 1'b1;
      light_relay = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_and_undefined();
      test_exhaust_thresholds();
      test_overrides();
      test_register_sweep();
      test_random_climate(260);

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
